// File: rtl/scpf_pkg.sv
`timescale 1ns / 1ps

package scpf_pkg;

    localparam int PCNT_W      = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_PARAM = 2'd1;
    localparam logic [1:0] OP_RX    = 2'd2;

    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_PAY  = 2'd1;
    localparam logic [1:0] KIND_STAT = 2'd2;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_HDR = 2'd1;
    localparam logic [1:0] ST_SUM = 2'd2;
    localparam logic [1:0] ST_LEN = 2'd3;

    localparam logic [7:0] HDR_BYTE0 = 8'hEF;
    localparam logic [7:0] HDR_BYTE1 = 8'h01;
    localparam logic [7:0] FLAG_CMD  = 8'h01;
    localparam logic [7:0] LEN_BASE  = 8'd3;

    localparam logic [3:0] TX_HDR_LAST = 4'd9;
    localparam logic [3:0] TX_SUM_LAST = 4'd11;
    localparam logic [3:0] PR_SUM_LAST = 4'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [7:0]        data_byte;
        logic [PCNT_W-1:0] param_count;
    } t_in_word;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       last;
        logic [1:0] status;
        logic [7:0] reply_code;
    } t_out_word;

    typedef enum logic [1:0] {
        JOB_START,
        JOB_PARAM,
        JOB_RX
    } t_job_kind;

    typedef struct packed {
        t_job_kind  job_kind;
        logic [7:0] data;
        logic [7:0] len;
        logic [15:0] sum;
        logic       fin;
        t_out_word  rx_word;
    } t_job;

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_H1,
        PH_A0,
        PH_A1,
        PH_A2,
        PH_A3,
        PH_FLAG,
        PH_LENH,
        PH_LENL,
        PH_CODE,
        PH_DATA,
        PH_SUMH,
        PH_SUML
    } t_rx_phase;

endpackage

// File: rtl/sensor_command_packet_framer_unit.sv
`timescale 1ns / 1ps

// Command framer and reply checker for the sensor packet link. The front end takes one input word
// per cycle while its four-entry job queue has room; transmit framing and reply checking state is
// updated there, and each word leaves at most one job. The back end expands jobs into result words
// at one word per cycle while its output register is empty or popped: a start command yields ten
// words (twelve with no parameters), a parameter byte one or, for the last, three, and a reply
// byte at most one. The sustained rate is therefore set by the back end's drain; a result reaches
// the output register at the earliest once its job has been written to the queue and read from it.

module sensor_command_packet_framer_unit #(
    parameter int MAX_PARAMS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata,
    input  logic                push,
    output logic                full,
    input  scpf_pkg::t_in_word  i_in_word,
    output logic                empty,
    input  logic                pop,
    output scpf_pkg::t_out_word o_out_word
);

    logic           job_push;
    scpf_pkg::t_job job_in;
    scpf_pkg::t_job job_head;
    logic           job_valid;
    logic           job_pop;
    logic [31:0]    dev_addr;

    scpf_front #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (push && !full),
        .i_in_word   (i_in_word),
        .o_job_push  (job_push),
        .o_job       (job_in),
        .o_dev_addr  (dev_addr)
    );

    scpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_valid (job_valid),
        .o_job   (job_head)
    );

    scpf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dev_addr (dev_addr),
        .i_q_valid  (job_valid),
        .i_job      (job_head),
        .o_q_pop    (job_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_word (o_out_word)
    );

endmodule

// File: rtl/scpf_front.sv
`timescale 1ns / 1ps

module scpf_front #(
    parameter int MAX_PARAMS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [31:0]          i_cfg_wdata,
    input  logic                 i_accept,
    input  scpf_pkg::t_in_word   i_in_word,
    output logic                 o_job_push,
    output scpf_pkg::t_job       o_job,
    output logic [31:0]          o_dev_addr
);

    localparam int CNT_MAX = (1 << scpf_pkg::PCNT_W) - 1;
    localparam int CAP     = (MAX_PARAMS > CNT_MAX) ? CNT_MAX : MAX_PARAMS;

    logic [31:0]                 r_dev_addr;
    logic [scpf_pkg::PCNT_W-1:0] r_tx_rem, n_tx_rem;
    logic                        r_tx_active, n_tx_active;
    logic [15:0]                 r_tx_sum, n_tx_sum;
    scpf_pkg::t_rx_phase         r_rx_phase, n_rx_phase;
    logic [15:0]                 r_rx_len, n_rx_len;
    logic [15:0]                 r_rx_cnt, n_rx_cnt;
    logic [15:0]                 r_rx_sum, n_rx_sum;
    logic [7:0]                  r_rx_code, n_rx_code;
    logic [7:0]                  r_rx_sum_hi, n_rx_sum_hi;

    logic [scpf_pkg::PCNT_W-1:0] cnt_sat;
    logic [7:0]                  tx_len;
    logic [7:0]                  b;
    logic [15:0]                 len_full;
    logic [15:0]                 cnt_inc;
    logic                        rx_emit;
    scpf_pkg::t_out_word         rx_word;

    assign o_dev_addr = r_dev_addr;
    assign b          = i_in_word.data_byte;

    always_comb begin
        cnt_sat = (32'(i_in_word.param_count) > 32'(CAP)) ?
                  scpf_pkg::PCNT_W'(CAP) : i_in_word.param_count;
        tx_len   = scpf_pkg::LEN_BASE + 8'(cnt_sat);
        len_full = {r_rx_len[15:8], b};
        cnt_inc  = r_rx_cnt + 16'd1;

        n_tx_rem    = r_tx_rem;
        n_tx_active = r_tx_active;
        n_tx_sum    = r_tx_sum;
        n_rx_phase  = r_rx_phase;
        n_rx_len    = r_rx_len;
        n_rx_cnt    = r_rx_cnt;
        n_rx_sum    = r_rx_sum;
        n_rx_code   = r_rx_code;
        n_rx_sum_hi = r_rx_sum_hi;

        rx_emit = 1'b0;
        rx_word = '0;
        rx_word.kind = scpf_pkg::KIND_STAT;
        rx_word.last = 1'b1;

        o_job_push = 1'b0;
        o_job      = '0;
        o_job.data = b;
        o_job.len  = tx_len;

        case (r_rx_phase)
            scpf_pkg::PH_HUNT: begin
                if (b != scpf_pkg::HDR_BYTE0) begin
                    rx_emit = 1'b1;
                    rx_word.status = scpf_pkg::ST_HDR;
                end else begin
                    n_rx_phase = scpf_pkg::PH_H1;
                end
            end
            scpf_pkg::PH_H1: begin
                if (b != scpf_pkg::HDR_BYTE1) begin
                    rx_emit = 1'b1;
                    rx_word.status = scpf_pkg::ST_HDR;
                end else begin
                    n_rx_phase = scpf_pkg::PH_A0;
                end
            end
            scpf_pkg::PH_A0: begin
                if (b != r_dev_addr[31:24]) begin
                    rx_emit = 1'b1;
                    rx_word.status = scpf_pkg::ST_HDR;
                end else begin
                    n_rx_phase = scpf_pkg::PH_A1;
                end
            end
            scpf_pkg::PH_A1: begin
                if (b != r_dev_addr[23:16]) begin
                    rx_emit = 1'b1;
                    rx_word.status = scpf_pkg::ST_HDR;
                end else begin
                    n_rx_phase = scpf_pkg::PH_A2;
                end
            end
            scpf_pkg::PH_A2: begin
                if (b != r_dev_addr[15:8]) begin
                    rx_emit = 1'b1;
                    rx_word.status = scpf_pkg::ST_HDR;
                end else begin
                    n_rx_phase = scpf_pkg::PH_A3;
                end
            end
            scpf_pkg::PH_A3: begin
                n_rx_phase = scpf_pkg::PH_FLAG;
            end
            scpf_pkg::PH_FLAG: begin
                n_rx_sum   = 16'(b);
                n_rx_code  = 8'd0;
                n_rx_cnt   = 16'd0;
                n_rx_phase = scpf_pkg::PH_LENH;
            end
            scpf_pkg::PH_LENH: begin
                n_rx_len   = {b, 8'd0};
                n_rx_sum   = r_rx_sum + 16'(b);
                n_rx_phase = scpf_pkg::PH_LENL;
            end
            scpf_pkg::PH_LENL: begin
                n_rx_len = len_full;
                n_rx_sum = r_rx_sum + 16'(b);
                if (len_full < 16'(scpf_pkg::LEN_BASE)) begin
                    rx_emit = 1'b1;
                    rx_word.status = scpf_pkg::ST_LEN;
                end else begin
                    n_rx_phase = scpf_pkg::PH_CODE;
                end
            end
            scpf_pkg::PH_CODE: begin
                n_rx_code  = b;
                n_rx_sum   = r_rx_sum + 16'(b);
                n_rx_cnt   = 16'd0;
                n_rx_phase = (r_rx_len > 16'(scpf_pkg::LEN_BASE)) ?
                             scpf_pkg::PH_DATA : scpf_pkg::PH_SUMH;
            end
            scpf_pkg::PH_DATA: begin
                n_rx_sum = r_rx_sum + 16'(b);
                n_rx_cnt = cnt_inc;
                if (cnt_inc >= r_rx_len - 16'(scpf_pkg::LEN_BASE)) begin
                    n_rx_phase = scpf_pkg::PH_SUMH;
                end
                rx_emit = 1'b1;
                rx_word.kind       = scpf_pkg::KIND_PAY;
                rx_word.out_byte   = b;
                rx_word.last       = 1'b0;
                rx_word.status     = scpf_pkg::ST_OK;
                rx_word.reply_code = r_rx_code;
            end
            scpf_pkg::PH_SUMH: begin
                n_rx_sum_hi = b;
                n_rx_phase  = scpf_pkg::PH_SUML;
            end
            scpf_pkg::PH_SUML: begin
                rx_emit = 1'b1;
                rx_word.reply_code = r_rx_code;
                rx_word.status = ({r_rx_sum_hi, b} == r_rx_sum) ?
                                 scpf_pkg::ST_OK : scpf_pkg::ST_SUM;
            end
            default: begin
                n_rx_phase = scpf_pkg::PH_HUNT;
            end
        endcase

        if (rx_emit && rx_word.kind == scpf_pkg::KIND_STAT) begin
            n_rx_phase = scpf_pkg::PH_HUNT;
        end
        o_job.rx_word = rx_word;

        case (i_in_word.opcode)
            scpf_pkg::OP_START: begin
                o_job_push     = i_accept;
                o_job.job_kind = scpf_pkg::JOB_START;
                o_job.sum      = 16'd1 + 16'(tx_len) + 16'(b);
                o_job.fin      = (cnt_sat == '0);
                n_tx_sum       = o_job.sum;
                n_tx_rem       = cnt_sat;
                n_tx_active    = (cnt_sat != '0);
            end
            scpf_pkg::OP_PARAM: begin
                o_job.job_kind = scpf_pkg::JOB_PARAM;
                o_job.sum      = r_tx_sum + 16'(b);
                o_job.fin      = (r_tx_rem == scpf_pkg::PCNT_W'(1));
                if (r_tx_active && r_tx_rem != '0) begin
                    o_job_push  = i_accept;
                    n_tx_sum    = o_job.sum;
                    n_tx_rem    = r_tx_rem - scpf_pkg::PCNT_W'(1);
                    n_tx_active = !o_job.fin;
                end else begin
                    n_tx_active = 1'b0;
                end
            end
            scpf_pkg::OP_RX: begin
                o_job.job_kind = scpf_pkg::JOB_RX;
                o_job_push     = i_accept && rx_emit;
            end
            default: begin
                o_job.job_kind = scpf_pkg::JOB_RX;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr  <= 32'hFFFF_FFFF;
            r_tx_rem    <= '0;
            r_tx_active <= 1'b0;
            r_tx_sum    <= '0;
            r_rx_phase  <= scpf_pkg::PH_HUNT;
            r_rx_len    <= '0;
            r_rx_cnt    <= '0;
            r_rx_sum    <= '0;
            r_rx_code   <= '0;
            r_rx_sum_hi <= '0;
        end else begin
            if (i_cfg_we) begin
                r_dev_addr <= i_cfg_wdata;
            end
            if (i_accept && (i_in_word.opcode == scpf_pkg::OP_START ||
                             i_in_word.opcode == scpf_pkg::OP_PARAM)) begin
                r_tx_rem    <= n_tx_rem;
                r_tx_active <= n_tx_active;
                r_tx_sum    <= n_tx_sum;
            end
            if (i_accept && i_in_word.opcode == scpf_pkg::OP_RX) begin
                r_rx_phase  <= n_rx_phase;
                r_rx_len    <= n_rx_len;
                r_rx_cnt    <= n_rx_cnt;
                r_rx_sum    <= n_rx_sum;
                r_rx_code   <= n_rx_code;
                r_rx_sum_hi <= n_rx_sum_hi;
            end
        end
    end

    a_active_has_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_active |-> (r_tx_rem != '0))
        else $error("transmit frame open with no parameter bytes left");

    a_data_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rx_phase == scpf_pkg::PH_DATA) |-> (r_rx_len > 16'(scpf_pkg::LEN_BASE)))
        else $error("reply payload phase entered with no payload length");

endmodule

// File: rtl/scpf_queue.sv
`timescale 1ns / 1ps

module scpf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  scpf_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output scpf_pkg::t_job o_job
);

    scpf_pkg::t_job                 r_mem [scpf_pkg::QUEUE_DEPTH];
    logic [scpf_pkg::QPTR_W-1:0]    r_wptr, r_rptr;
    logic [scpf_pkg::QPTR_W:0]      r_count;

    assign o_full  = (r_count == (scpf_pkg::QPTR_W + 1)'(scpf_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + scpf_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + scpf_pkg::QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (scpf_pkg::QPTR_W + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (scpf_pkg::QPTR_W + 1)'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("job popped from an empty queue");

endmodule

// File: rtl/scpf_back.sv
`timescale 1ns / 1ps

module scpf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [31:0]         i_dev_addr,
    input  logic                i_q_valid,
    input  scpf_pkg::t_job      i_job,
    output logic                o_q_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output scpf_pkg::t_out_word o_out_word
);

    logic                r_valid, n_valid;
    logic [3:0]          r_idx, n_idx;
    scpf_pkg::t_out_word r_out, n_out;

    logic                load;
    logic [3:0]          end_idx;
    scpf_pkg::t_out_word word;

    assign o_empty    = !r_valid;
    assign o_out_word = r_out;

    always_comb begin
        word      = '0;
        word.kind = scpf_pkg::KIND_TX;
        end_idx   = 4'd0;
        case (i_job.job_kind)
            scpf_pkg::JOB_START: begin
                end_idx = i_job.fin ? scpf_pkg::TX_SUM_LAST : scpf_pkg::TX_HDR_LAST;
                case (r_idx)
                    4'd0:    word.out_byte = scpf_pkg::HDR_BYTE0;
                    4'd1:    word.out_byte = scpf_pkg::HDR_BYTE1;
                    4'd2:    word.out_byte = i_dev_addr[31:24];
                    4'd3:    word.out_byte = i_dev_addr[23:16];
                    4'd4:    word.out_byte = i_dev_addr[15:8];
                    4'd5:    word.out_byte = i_dev_addr[7:0];
                    4'd6:    word.out_byte = scpf_pkg::FLAG_CMD;
                    4'd7:    word.out_byte = 8'd0;
                    4'd8:    word.out_byte = i_job.len;
                    4'd9:    word.out_byte = i_job.data;
                    4'd10:   word.out_byte = i_job.sum[15:8];
                    default: word.out_byte = i_job.sum[7:0];
                endcase
            end
            scpf_pkg::JOB_PARAM: begin
                end_idx = i_job.fin ? scpf_pkg::PR_SUM_LAST : 4'd0;
                case (r_idx)
                    4'd0:    word.out_byte = i_job.data;
                    4'd1:    word.out_byte = i_job.sum[15:8];
                    default: word.out_byte = i_job.sum[7:0];
                endcase
            end
            default: begin
                word = i_job.rx_word;
            end
        endcase
        if (i_job.job_kind != scpf_pkg::JOB_RX) begin
            word.last = i_job.fin && (r_idx == end_idx);
        end

        load    = i_q_valid && (!r_valid || i_pop);
        o_q_pop = load && (r_idx == end_idx);

        n_valid = r_valid && !i_pop;
        n_out   = r_out;
        n_idx   = r_idx;
        if (load) begin
            n_valid = 1'b1;
            n_out   = word;
            n_idx   = o_q_pop ? 4'd0 : r_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    a_job_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 4'd0) |-> i_q_valid)
        else $error("job left the queue before all of its words were sent");

endmodule

// File: tb/sensor_command_packet_framer_unit_tb.sv
`timescale 1ns / 1ps

module sensor_command_packet_framer_unit_tb;

    localparam int         MAX_PARAMS   = 32;
    localparam logic [1:0] OP_NONE      = 2'd3;
    localparam int         CYCLE_LIMIT  = 300000;
    localparam int         DRAIN_SLACK  = 24;

    typedef enum int {
        RPL_GOOD,
        RPL_BAD_SUM,
        RPL_BAD_HDR,
        RPL_BAD_LEN
    } t_reply_flavor;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [31:0]         i_cfg_wdata = '0;
    logic                push        = 1'b0;
    logic                full;
    scpf_pkg::t_in_word  i_in_word   = '0;
    logic                empty;
    logic                pop         = 1'b0;
    scpf_pkg::t_out_word o_out_word;

    logic [31:0]         dev_addr  = 32'hFFFF_FFFF;
    int                  tx_left   = 0;
    bit                  tx_open   = 1'b0;
    logic [15:0]         tx_sum    = '0;
    scpf_pkg::t_rx_phase rx_ph     = scpf_pkg::PH_HUNT;
    logic [15:0]         rx_len    = '0;
    logic [15:0]         rx_cnt    = '0;
    logic [15:0]         rx_sum    = '0;
    logic [7:0]          rx_code   = '0;
    logic [7:0]          rx_sum_hi = '0;

    scpf_pkg::t_out_word frame_expect_q[$];
    scpf_pkg::t_in_word  tx_plan_q[$];
    scpf_pkg::t_in_word  rx_plan_q[$];
    scpf_pkg::t_out_word exp_w;

    int err_count      = 0;
    int items_sent     = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int recv_hold_req  = 0;
    int recv_hold_left = 0;

    sensor_command_packet_framer_unit #(
        .MAX_PARAMS(MAX_PARAMS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .push       (push),
        .full       (full),
        .i_in_word  (i_in_word),
        .empty      (empty),
        .pop        (pop),
        .o_out_word (o_out_word)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic scpf_pkg::t_in_word make_word(logic [1:0] op, logic [7:0] b,
                                                     logic [5:0] cnt);
        scpf_pkg::t_in_word w;
        w.opcode      = op;
        w.data_byte   = b;
        w.param_count = cnt;
        return w;
    endfunction

    function void queue_result(logic [1:0] kind, logic [7:0] b, logic l, logic [1:0] st,
                               logic [7:0] code);
        scpf_pkg::t_out_word w;
        w.kind       = kind;
        w.out_byte   = b;
        w.last       = l;
        w.status     = st;
        w.reply_code = code;
        frame_expect_q.push_back(w);
    endfunction

    function void queue_tx(logic [7:0] b, logic l);
        queue_result(scpf_pkg::KIND_TX, b, l, scpf_pkg::ST_OK, 8'h00);
    endfunction

    function void finish_reply(logic [1:0] st, logic [7:0] code);
        rx_ph = scpf_pkg::PH_HUNT;
        queue_result(scpf_pkg::KIND_STAT, 8'h00, 1'b1, st, code);
    endfunction

    function void predict_start(logic [7:0] code, logic [5:0] cnt);
        int          n;
        logic [15:0] len;
        n   = (cnt > MAX_PARAMS) ? MAX_PARAMS : int'(cnt);
        len = 16'(scpf_pkg::LEN_BASE) + 16'(n);
        queue_tx(scpf_pkg::HDR_BYTE0, 1'b0);
        queue_tx(scpf_pkg::HDR_BYTE1, 1'b0);
        queue_tx(dev_addr[31:24], 1'b0);
        queue_tx(dev_addr[23:16], 1'b0);
        queue_tx(dev_addr[15:8], 1'b0);
        queue_tx(dev_addr[7:0], 1'b0);
        queue_tx(scpf_pkg::FLAG_CMD, 1'b0);
        queue_tx(len[15:8], 1'b0);
        queue_tx(len[7:0], 1'b0);
        queue_tx(code, 1'b0);
        tx_sum  = 16'(scpf_pkg::FLAG_CMD) + 16'(len[15:8]) + 16'(len[7:0]) + 16'(code);
        tx_left = n;
        tx_open = (n != 0);
        if (n == 0) begin
            queue_tx(tx_sum[15:8], 1'b0);
            queue_tx(tx_sum[7:0], 1'b1);
        end
    endfunction

    function void predict_param(logic [7:0] b);
        if (!tx_open || tx_left == 0) begin
            tx_open = 1'b0;
            return;
        end
        queue_tx(b, 1'b0);
        tx_sum  = tx_sum + 16'(b);
        tx_left = tx_left - 1;
        if (tx_left == 0) begin
            tx_open = 1'b0;
            queue_tx(tx_sum[15:8], 1'b0);
            queue_tx(tx_sum[7:0], 1'b1);
        end
    endfunction

    function void predict_rx(logic [7:0] b);
        case (rx_ph)
            scpf_pkg::PH_HUNT: begin
                if (b != scpf_pkg::HDR_BYTE0) finish_reply(scpf_pkg::ST_HDR, 8'h00);
                else rx_ph = scpf_pkg::PH_H1;
            end
            scpf_pkg::PH_H1: begin
                if (b != scpf_pkg::HDR_BYTE1) finish_reply(scpf_pkg::ST_HDR, 8'h00);
                else rx_ph = scpf_pkg::PH_A0;
            end
            scpf_pkg::PH_A0: begin
                if (b != dev_addr[31:24]) finish_reply(scpf_pkg::ST_HDR, 8'h00);
                else rx_ph = scpf_pkg::PH_A1;
            end
            scpf_pkg::PH_A1: begin
                if (b != dev_addr[23:16]) finish_reply(scpf_pkg::ST_HDR, 8'h00);
                else rx_ph = scpf_pkg::PH_A2;
            end
            scpf_pkg::PH_A2: begin
                if (b != dev_addr[15:8]) finish_reply(scpf_pkg::ST_HDR, 8'h00);
                else rx_ph = scpf_pkg::PH_A3;
            end
            scpf_pkg::PH_A3: begin
                rx_ph = scpf_pkg::PH_FLAG;
            end
            scpf_pkg::PH_FLAG: begin
                rx_sum  = 16'(b);
                rx_code = 8'h00;
                rx_cnt  = 16'h0000;
                rx_ph   = scpf_pkg::PH_LENH;
            end
            scpf_pkg::PH_LENH: begin
                rx_len = {b, 8'h00};
                rx_sum = rx_sum + 16'(b);
                rx_ph  = scpf_pkg::PH_LENL;
            end
            scpf_pkg::PH_LENL: begin
                rx_len[7:0] = b;
                rx_sum      = rx_sum + 16'(b);
                if (rx_len < 16'(scpf_pkg::LEN_BASE)) finish_reply(scpf_pkg::ST_LEN, 8'h00);
                else rx_ph = scpf_pkg::PH_CODE;
            end
            scpf_pkg::PH_CODE: begin
                rx_code = b;
                rx_sum  = rx_sum + 16'(b);
                rx_cnt  = 16'h0000;
                rx_ph   = (rx_len > 16'(scpf_pkg::LEN_BASE)) ? scpf_pkg::PH_DATA :
                                                               scpf_pkg::PH_SUMH;
            end
            scpf_pkg::PH_DATA: begin
                rx_sum = rx_sum + 16'(b);
                rx_cnt = rx_cnt + 16'd1;
                if (rx_cnt >= rx_len - 16'(scpf_pkg::LEN_BASE)) rx_ph = scpf_pkg::PH_SUMH;
                queue_result(scpf_pkg::KIND_PAY, b, 1'b0, scpf_pkg::ST_OK, rx_code);
            end
            scpf_pkg::PH_SUMH: begin
                rx_sum_hi = b;
                rx_ph     = scpf_pkg::PH_SUML;
            end
            scpf_pkg::PH_SUML: begin
                if ({rx_sum_hi, b} == rx_sum) finish_reply(scpf_pkg::ST_OK, rx_code);
                else finish_reply(scpf_pkg::ST_SUM, rx_code);
            end
            default: begin
                rx_ph = scpf_pkg::PH_HUNT;
            end
        endcase
    endfunction

    function void predict_word(scpf_pkg::t_in_word w);
        case (w.opcode)
            scpf_pkg::OP_START: predict_start(w.data_byte, w.param_count);
            scpf_pkg::OP_PARAM: predict_param(w.data_byte);
            scpf_pkg::OP_RX:    predict_rx(w.data_byte);
            default:  ;
        endcase
    endfunction

    task automatic send_word(input scpf_pkg::t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (full);
        predict_word(w);
        items_sent++;
    endtask

    task automatic send_op(input logic [1:0] op, input logic [7:0] b, input logic [5:0] cnt);
        send_word(make_word(op, b, cnt));
    endtask

    task automatic wait_for_drain();
        push <= 1'b0;
        while (frame_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic write_address(input logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        dev_addr     = value;
    endtask

    task automatic add_command(input logic [5:0] cnt, input int n_sent);
        tx_plan_q.push_back(make_word(scpf_pkg::OP_START, 8'($urandom), cnt));
        for (int i = 0; i < n_sent; i++) begin
            tx_plan_q.push_back(make_word(scpf_pkg::OP_PARAM, 8'($urandom), 6'($urandom)));
        end
    endtask

    task automatic add_reply(input int n_pay, input t_reply_flavor flavor);
        logic [7:0]  fb[$];
        logic [15:0] len;
        logic [15:0] sum;
        int          p;
        len = 16'(n_pay) + 16'(scpf_pkg::LEN_BASE);
        fb  = '{scpf_pkg::HDR_BYTE0, scpf_pkg::HDR_BYTE1, dev_addr[31:24], dev_addr[23:16],
                dev_addr[15:8], 8'($urandom), 8'($urandom), len[15:8], len[7:0],
                8'($urandom)};
        for (int i = 0; i < n_pay; i++) fb.push_back(8'($urandom));
        sum = 16'h0000;
        for (int i = 6; i < fb.size(); i++) sum = sum + 16'(fb[i]);
        fb.push_back(sum[15:8]);
        fb.push_back(sum[7:0]);
        case (flavor)
            RPL_BAD_SUM: begin
                p     = fb.size() - 1 - $urandom_range(1);
                fb[p] = fb[p] ^ 8'($urandom_range(1, 255));
            end
            RPL_BAD_HDR: begin
                p     = $urandom_range(4);
                fb[p] = fb[p] ^ 8'($urandom_range(1, 255));
                while (fb.size() > p + 1) void'(fb.pop_back());
            end
            RPL_BAD_LEN: begin
                fb[7] = 8'h00;
                fb[8] = 8'($urandom_range(2));
                while (fb.size() > 9) void'(fb.pop_back());
            end
            default: ;
        endcase
        foreach (fb[i]) rx_plan_q.push_back(make_word(scpf_pkg::OP_RX, fb[i], 6'($urandom)));
    endtask

    task automatic add_random_command();
        int r;
        int cnt;
        int n;
        r   = $urandom_range(99);
        cnt = (r < 85) ? $urandom_range(0, 6) :
              (r < 95) ? $urandom_range(7, 32) : $urandom_range(33, 63);
        n   = (cnt > MAX_PARAMS) ? MAX_PARAMS : cnt;
        if ($urandom_range(9) == 0) n = $urandom_range(0, n);
        add_command(6'(cnt), n);
    endtask

    task automatic add_random_reply();
        int r;
        int n;
        t_reply_flavor flavor;
        n      = ($urandom_range(9) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 6);
        r      = $urandom_range(99);
        flavor = (r < 70) ? RPL_GOOD : (r < 80) ? RPL_BAD_SUM :
                 (r < 90) ? RPL_BAD_HDR : RPL_BAD_LEN;
        add_reply(n, flavor);
    endtask

    task automatic flush_plans();
        bit take_rx;
        while (tx_plan_q.size() != 0 || rx_plan_q.size() != 0) begin
            if (tx_plan_q.size() == 0) take_rx = 1'b1;
            else if (rx_plan_q.size() == 0) take_rx = 1'b0;
            else take_rx = 1'($urandom_range(1));
            if (take_rx) send_word(rx_plan_q.pop_front());
            else send_word(tx_plan_q.pop_front());
        end
    endtask

    task automatic send_mixed_burst();
        int r;
        r = $urandom_range(99);
        if (r < 30) begin
            add_random_command();
        end else if (r < 60) begin
            add_random_reply();
        end else if (r < 85) begin
            add_random_command();
            add_random_reply();
        end else begin
            repeat ($urandom_range(1, 3)) begin
                send_op(2'($urandom_range(3)), 8'($urandom), 6'($urandom));
            end
        end
        flush_plans();
    endtask

    task automatic test_directed();
        logic [7:0] rx_seq[$];
        send_idle_pct = 19;
        recv_idle_pct = 48;
        send_op(scpf_pkg::OP_START, 8'h00, 6'd0);
        wait_for_drain();
        write_address(32'h0000_0000);
        send_op(scpf_pkg::OP_START, 8'hFF, 6'd63);
        send_op(scpf_pkg::OP_PARAM, 8'hFF, 6'd63);
        send_op(scpf_pkg::OP_START, 8'hA5, 6'd1);
        send_op(scpf_pkg::OP_PARAM, 8'h00, 6'd0);
        send_op(scpf_pkg::OP_PARAM, 8'h5A, 6'd21);
        send_op(OP_NONE, 8'hFF, 6'd63);
        rx_seq = '{8'h00, 8'hEF, 8'h02, 8'hEF, 8'h01, 8'h00, 8'h01,
                   8'hEF, 8'h01, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h01, 8'h00, 8'h02,
                   8'hEF, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h03,
                   8'h80, 8'h01, 8'h83};
        foreach (rx_seq[i]) send_op(scpf_pkg::OP_RX, rx_seq[i], 6'($urandom));
        wait_for_drain();
    endtask

    task automatic test_random_phases();
        int target;
        for (int ph = 0; ph < 3; ph++) begin
            wait_for_drain();
            case (ph)
                0: begin
                    send_idle_pct = 19;
                    recv_idle_pct = 48;
                    write_address($urandom);
                end
                1: begin
                    send_idle_pct = 48;
                    recv_idle_pct = 19;
                    write_address({scpf_pkg::HDR_BYTE0, scpf_pkg::HDR_BYTE1,
                                   scpf_pkg::HDR_BYTE0, scpf_pkg::FLAG_CMD});
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    write_address(32'hFFFF_FFFF);
                end
            endcase
            target = items_sent + 15;
            while (items_sent < target) send_mixed_burst();
        end
        wait_for_drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_address($urandom);
        recv_hold_req = 400;
        repeat (14) send_op(scpf_pkg::OP_START, 8'($urandom), 6'd0);
        wait_for_drain();
        add_command(6'd5, 5);
        add_random_reply();
        flush_plans();
        wait_for_drain();
    endtask

    task automatic test_long_reply();
        send_idle_pct = 19;
        recv_idle_pct = 48;
        add_reply(253, RPL_GOOD);
        add_random_command();
        flush_plans();
        wait_for_drain();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (frame_expect_q.size() == 0) begin
                $display("%0t: expected no result word, actual %h", $time, o_out_word);
                err_count++;
            end else begin
                exp_w = frame_expect_q.pop_front();
                if (o_out_word.kind !== exp_w.kind || o_out_word.out_byte !== exp_w.out_byte ||
                    o_out_word.last !== exp_w.last || o_out_word.status !== exp_w.status ||
                    o_out_word.reply_code !== exp_w.reply_code) begin
                    $display("%0t: expected kind %0d byte %h last %0d status %0d code %h",
                             $time, exp_w.kind, exp_w.out_byte, exp_w.last, exp_w.status,
                             exp_w.reply_code);
                    $display("%0t: actual   kind %0d byte %h last %0d status %0d code %h",
                             $time, o_out_word.kind, o_out_word.out_byte, o_out_word.last,
                             o_out_word.status, o_out_word.reply_code);
                    err_count++;
                end
            end
        end
        if (recv_hold_req != 0) begin
            recv_hold_left = recv_hold_req;
            recv_hold_req  = 0;
        end
        if (recv_hold_left != 0) begin
            recv_hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d result words pending", $time, frame_expect_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_phases();
        test_backpressure();
        test_long_reply();
        wait_for_drain();
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
